@@ hdl/c65as_pkg.sv @@
// Package for the 6502 addressing sequencer: item structs, mode and access codes,
// the one-hot step encoding and the sequencer state record.
// No dependencies.
package c65as_pkg;

    // addressing mode codes
    localparam logic [3:0] MD_IMP = 4'd0;
    localparam logic [3:0] MD_ACC = 4'd1;
    localparam logic [3:0] MD_IMM = 4'd2;
    localparam logic [3:0] MD_ZP  = 4'd3;
    localparam logic [3:0] MD_ZPX = 4'd4;
    localparam logic [3:0] MD_ZPY = 4'd5;
    localparam logic [3:0] MD_REL = 4'd6;
    localparam logic [3:0] MD_ABS = 4'd7;
    localparam logic [3:0] MD_ABX = 4'd8;
    localparam logic [3:0] MD_ABY = 4'd9;
    localparam logic [3:0] MD_IND = 4'd10;
    localparam logic [3:0] MD_IZX = 4'd11;
    localparam logic [3:0] MD_IZY = 4'd12;

    // access kinds
    localparam logic [1:0] ACC_READ  = 2'd0;
    localparam logic [1:0] ACC_WRITE = 2'd1;

    // item commands
    localparam logic CMD_START = 1'b0;

    localparam logic [7:0] BYTE_MASK = 8'hFF;

    // addressing step, one-hot
    typedef enum logic [4:0] {
        STEP_IDLE = 5'b00001,
        STEP_1    = 5'b00010,
        STEP_2    = 5'b00100,
        STEP_3    = 5'b01000,
        STEP_4    = 5'b10000
    } t_step;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  mode;
        logic [1:0]  access_kind;
        logic [15:0] start_pc;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  data_in;
    } t_in_item;

    typedef struct packed {
        logic [15:0] address_out;
        logic [15:0] pc_out;
        logic        operand_ready;
        logic        op_merged;
        logic        page_crossed;
    } t_out_item;

    typedef struct packed {
        t_step       step;
        logic [3:0]  mode_held;
        logic [1:0]  kind_held;
        logic [15:0] prog_counter;
        logic [7:0]  x_held;
        logic [7:0]  y_held;
        logic [15:0] addr_reg;
        logic [15:0] bus_addr;
        logic        carry_flag;
    } t_seq_state;

endpackage

@@ hdl/c65as_step.sv @@
// Next-state and result logic for one bus cycle of the addressing sequencer.
// Depends on c65as_pkg.
module c65as_step (
    input  c65as_pkg::t_seq_state i_state,
    input  c65as_pkg::t_in_item   i_item,
    output c65as_pkg::t_seq_state o_state,
    output c65as_pkg::t_out_item  o_result
);
    import c65as_pkg::*;

    t_seq_state s;
    logic       rdy;
    logic       mrg;
    logic       done;
    logic       wr_any;
    logic       wr_only;
    logic [7:0] idx;
    logic [8:0] sum;
    t_step      nxt;

    // one step of the sequence
    always_comb begin
        s       = i_state;
        rdy     = 1'b0;
        mrg     = 1'b0;
        done    = 1'b0;
        nxt     = STEP_IDLE;
        sum     = 9'd0;
        wr_any  = i_state.kind_held != ACC_READ;
        wr_only = i_state.kind_held == ACC_WRITE;
        idx     = (i_state.mode_held == MD_ZPX || i_state.mode_held == MD_ABX)
                  ? i_state.x_held : i_state.y_held;

        if (i_item.cmd == CMD_START) begin
            // latch the instruction context
            s.mode_held    = i_item.mode;
            s.kind_held    = i_item.access_kind;
            s.prog_counter = i_item.start_pc;
            s.x_held       = i_item.index_x;
            s.y_held       = i_item.index_y;
            s.carry_flag   = 1'b0;
            s.step         = STEP_IDLE;
            if (i_item.mode == MD_IMM || i_item.mode == MD_REL) begin
                s.bus_addr     = i_item.start_pc;
                s.prog_counter = i_item.start_pc + 16'd1;
                rdy            = 1'b1;
            end else if (i_item.mode >= MD_ZP && i_item.mode <= MD_IZY) begin
                s.bus_addr     = i_item.start_pc;
                s.prog_counter = i_item.start_pc + 16'd1;
                s.step         = STEP_1;
            end else begin
                rdy = 1'b1;
            end
        end else if (i_state.step != STEP_IDLE) begin
            case (i_state.mode_held)
                MD_ZP: begin
                    s.addr_reg = {8'h00, i_item.data_in};
                    s.bus_addr = s.addr_reg;
                    done       = 1'b1;
                end
                MD_ZPX, MD_ZPY: begin
                    if (i_state.step == STEP_1) begin
                        s.addr_reg = {8'h00, i_item.data_in};
                        s.bus_addr = s.addr_reg;
                        nxt        = STEP_2;
                    end else begin
                        s.addr_reg[7:0] = i_state.addr_reg[7:0] + idx;
                        s.bus_addr      = s.addr_reg;
                        done            = 1'b1;
                    end
                end
                MD_ABS: begin
                    if (i_state.step == STEP_1) begin
                        s.addr_reg[7:0] = i_item.data_in;
                        s.bus_addr      = i_state.prog_counter;
                        s.prog_counter  = i_state.prog_counter + 16'd1;
                        nxt             = STEP_2;
                    end else begin
                        s.addr_reg[15:8] = i_item.data_in;
                        s.bus_addr       = s.addr_reg;
                        done             = 1'b1;
                    end
                end
                MD_ABX, MD_ABY: begin
                    if (i_state.step == STEP_1) begin
                        s.addr_reg     = {8'h00, i_item.data_in};
                        s.bus_addr     = i_state.prog_counter;
                        s.prog_counter = i_state.prog_counter + 16'd1;
                        nxt            = STEP_2;
                    end else if (i_state.step == STEP_2) begin
                        // low byte index add, fix-up cycle on carry or any write
                        sum          = {1'b0, i_state.addr_reg[7:0]} + {1'b0, idx};
                        s.carry_flag = sum[8];
                        s.addr_reg   = {i_item.data_in, sum[7:0]};
                        s.bus_addr   = s.addr_reg;
                        if (wr_any || sum[8]) begin
                            nxt = STEP_3;
                        end else begin
                            rdy = 1'b1;
                        end
                    end else begin
                        s.addr_reg[15:8] = i_state.addr_reg[15:8]
                                           + {7'd0, i_state.carry_flag};
                        s.bus_addr       = s.addr_reg;
                        done             = 1'b1;
                    end
                end
                MD_IND: begin
                    if (i_state.step == STEP_1) begin
                        s.addr_reg[7:0] = i_item.data_in;
                        s.bus_addr      = i_state.prog_counter;
                        s.prog_counter  = i_state.prog_counter + 16'd1;
                        nxt             = STEP_2;
                    end else if (i_state.step == STEP_2) begin
                        s.addr_reg[15:8] = i_item.data_in;
                        s.bus_addr       = s.addr_reg;
                        nxt              = STEP_3;
                    end else if (i_state.step == STEP_3) begin
                        // pointer increment wraps within its page
                        s.addr_reg[7:0] = i_item.data_in;
                        s.bus_addr[7:0] = i_state.bus_addr[7:0] + 8'd1;
                        nxt             = STEP_4;
                    end else begin
                        s.addr_reg[15:8] = i_item.data_in;
                        s.bus_addr       = s.addr_reg;
                        rdy              = 1'b1;
                        mrg              = 1'b1;
                    end
                end
                MD_IZX: begin
                    if (i_state.step == STEP_1) begin
                        s.bus_addr = {8'h00, i_item.data_in};
                        nxt        = STEP_2;
                    end else if (i_state.step == STEP_2) begin
                        s.bus_addr[7:0] = i_state.bus_addr[7:0] + i_state.x_held;
                        nxt             = STEP_3;
                    end else if (i_state.step == STEP_3) begin
                        s.addr_reg[7:0] = i_item.data_in;
                        s.bus_addr[7:0] = i_state.bus_addr[7:0] + 8'd1;
                        nxt             = STEP_4;
                    end else begin
                        s.addr_reg[15:8] = i_item.data_in;
                        s.bus_addr       = s.addr_reg;
                        done             = 1'b1;
                    end
                end
                MD_IZY: begin
                    if (i_state.step == STEP_1) begin
                        s.bus_addr = {8'h00, i_item.data_in};
                        nxt        = STEP_2;
                    end else if (i_state.step == STEP_2) begin
                        s.addr_reg[7:0] = i_item.data_in;
                        s.bus_addr[7:0] = i_state.bus_addr[7:0] + 8'd1;
                        nxt             = STEP_3;
                    end else if (i_state.step == STEP_3) begin
                        // index the pointer, address register keeps the base
                        sum              = {1'b0, i_state.addr_reg[7:0]}
                                           + {1'b0, i_state.y_held};
                        s.carry_flag     = sum[8];
                        s.addr_reg[15:8] = i_item.data_in;
                        s.bus_addr       = {i_item.data_in, sum[7:0]};
                        if (wr_any || sum[8]) begin
                            nxt = STEP_4;
                        end else begin
                            rdy = 1'b1;
                        end
                    end else begin
                        s.bus_addr[15:8] = i_state.bus_addr[15:8]
                                           + {7'd0, i_state.carry_flag};
                        done             = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (done) begin
                rdy = 1'b1;
                mrg = wr_only;
            end
            s.step = nxt;
        end
    end

    assign o_state                = s;
    assign o_result.address_out   = s.bus_addr;
    assign o_result.pc_out        = s.prog_counter;
    assign o_result.operand_ready = rdy;
    assign o_result.op_merged     = mrg;
    assign o_result.page_crossed  = s.carry_flag & (|BYTE_MASK);

endmodule

@@ hdl/cpu6502_addressing_sequencer.sv @@
// 6502 addressing-mode sequencer: one result item for every input item, with
// a state register and a result register. Depends on c65as_pkg and c65as_step.
//
// Every input item is one CPU bus cycle: a start item (cmd 0) latches mode,
// access kind, PC, X and Y; a cycle item (cmd 1) brings the data bus byte and
// advances the sequence by one step. The result is held in an output register
// in the cycle after acceptance. New items are taken every clock unless
// o_in_stall is raised, which happens only while a result is held and the
// output side stalls; without that stall throughput is one item per clock. A
// start item abandons any running sequence.
module cpu6502_addressing_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  c65as_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output c65as_pkg::t_out_item o_out_item
);
    import c65as_pkg::*;

    t_seq_state r_state;
    t_seq_state n_state;
    t_out_item  r_out;
    t_out_item  n_out;
    logic       r_out_valid;
    logic       in_take;

    // hold inputs only while a result waits on a stalled output
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_take    = i_in_valid & ~o_in_stall;

    c65as_step u_step (
        .i_state  (r_state),
        .i_item   (i_in_item),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{step: STEP_IDLE, mode_held: 4'd0, kind_held: 2'd0,
                         prog_counter: 16'd0, x_held: 8'd0, y_held: 8'd0,
                         addr_reg: 16'd0, bus_addr: 16'd0, carry_flag: 1'b0};
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // an accepted item always leaves a result behind
    a_take_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> o_out_valid)
        else $error("accepted item produced no result");

    // a merged operation only happens on the final addressing cycle
    a_merge_is_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_item.op_merged || o_out_item.operand_ready))
        else $error("op_merged without operand_ready");

    // a ready result leaves the sequencer idle
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && n_out.operand_ready) |=> (r_state.step == STEP_IDLE))
        else $error("sequence still running after operand_ready");
`endif

endmodule
